/* hdl/mte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg
// Types, character constants and the Morse code table of the text encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Output characters
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNone  = 8'h00;

  // Separator counts for a job
  localparam logic [1:0] SepNone = 2'd0;
  localparam logic [1:0] SepChar = 2'd1;
  localparam logic [1:0] SepWord = 2'd2;

  // Input request
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } mte_in_t;

  // Output result
  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       run_last;
    logic       message_done;
  } mte_out_t;

  // Morse code: len elements, first element at bit len-1, 1 = dash
  typedef struct packed {
    logic [2:0] len;
    logic [6:0] pat;
  } mte_code_t;

  // Work item passed from the front to the back
  typedef struct packed {
    logic [1:0] sep;   // space bytes before the code
    logic [2:0] len;   // elements left; zero with no separators is a bare end marker
    logic [6:0] pat;
    logic       last;  // end of message
  } mte_job_t;

  function automatic mte_code_t mk(input logic [2:0] len, input logic [6:0] pat);
    mte_code_t c;
    c.len = len;
    c.pat = pat;
    return c;
  endfunction

  // Upper-case byte to Morse code; len zero means no code
  function automatic mte_code_t code_lookup(input logic [7:0] ch);
    mte_code_t c;
    unique case (ch)
      "!":   c = mk(3'd6, 7'b101011);
      "$":   c = mk(3'd7, 7'b0001001);
      8'h22: c = mk(3'd6, 7'b010010);
      8'h27: c = mk(3'd6, 7'b011110);
      "(":   c = mk(3'd5, 7'b10110);
      ")":   c = mk(3'd6, 7'b101101);
      ",":   c = mk(3'd6, 7'b110011);
      "-":   c = mk(3'd6, 7'b100001);
      ".":   c = mk(3'd6, 7'b010101);
      "/":   c = mk(3'd5, 7'b10010);
      "0":   c = mk(3'd5, 7'b11111);
      "1":   c = mk(3'd5, 7'b01111);
      "2":   c = mk(3'd5, 7'b00111);
      "3":   c = mk(3'd5, 7'b00011);
      "4":   c = mk(3'd5, 7'b00001);
      "5":   c = mk(3'd5, 7'b00000);
      "6":   c = mk(3'd5, 7'b10000);
      "7":   c = mk(3'd5, 7'b11000);
      "8":   c = mk(3'd5, 7'b11100);
      "9":   c = mk(3'd5, 7'b11110);
      ":":   c = mk(3'd6, 7'b111000);
      ";":   c = mk(3'd6, 7'b101010);
      "=":   c = mk(3'd5, 7'b10001);
      "?":   c = mk(3'd6, 7'b001100);
      "@":   c = mk(3'd6, 7'b011010);
      "A":   c = mk(3'd2, 7'b01);
      "B":   c = mk(3'd4, 7'b1000);
      "C":   c = mk(3'd4, 7'b1010);
      "D":   c = mk(3'd3, 7'b100);
      "E":   c = mk(3'd1, 7'b0);
      "F":   c = mk(3'd4, 7'b0010);
      "G":   c = mk(3'd3, 7'b110);
      "H":   c = mk(3'd4, 7'b0000);
      "I":   c = mk(3'd2, 7'b00);
      "J":   c = mk(3'd4, 7'b0111);
      "K":   c = mk(3'd3, 7'b101);
      "L":   c = mk(3'd4, 7'b0100);
      "M":   c = mk(3'd2, 7'b11);
      "N":   c = mk(3'd2, 7'b10);
      "O":   c = mk(3'd3, 7'b111);
      "P":   c = mk(3'd4, 7'b0110);
      "Q":   c = mk(3'd4, 7'b1101);
      "R":   c = mk(3'd3, 7'b010);
      "S":   c = mk(3'd3, 7'b000);
      "T":   c = mk(3'd1, 7'b1);
      "U":   c = mk(3'd3, 7'b001);
      "V":   c = mk(3'd4, 7'b0001);
      "W":   c = mk(3'd3, 7'b011);
      "X":   c = mk(3'd4, 7'b1001);
      "Y":   c = mk(3'd4, 7'b1011);
      "Z":   c = mk(3'd4, 7'b1100);
      "_":   c = mk(3'd6, 7'b001101);
      default: c = mk(3'd0, 7'b0);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/mte_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mte_front
// Accepts text bytes, folds case, looks up the code and tracks gaps; writes
// one job per byte that yields output into the job queue.
// ----------------------------------------------------------------------------
module mte_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  mte_pkg::mte_in_t    in_item_i,
  input  wire                 q_full_i,
  output logic                q_wr_o,
  output mte_pkg::mte_job_t   q_data_o
);
  import mte_pkg::*;

  logic      any_sent_q, any_sent_d;
  logic      gap_q, gap_d;
  logic      accept;
  logic [7:0] ch;
  mte_code_t code;
  logic      has_code;

  // Case fold and table lookup
  always_comb begin
    ch = in_item_i.char_code;
    if (ch >= "a" && ch <= "z") begin
      ch = ch - 8'd32;
    end
  end

  assign code     = code_lookup(ch);
  assign has_code = (code.len != 3'd0);
  assign accept   = push_i && !q_full_i;

  // Job build and message state update
  always_comb begin
    any_sent_d    = any_sent_q;
    gap_d         = gap_q;
    q_data_o.sep  = SepNone;
    q_data_o.len  = code.len;
    q_data_o.pat  = code.pat;
    q_data_o.last = in_item_i.end_of_text;
    if (has_code) begin
      if (any_sent_q) begin
        q_data_o.sep = gap_q ? SepWord : SepChar;
      end
      any_sent_d = 1'b1;
      gap_d      = 1'b0;
    end else if (any_sent_q) begin
      gap_d = 1'b1;
    end
    if (in_item_i.end_of_text) begin
      any_sent_d = 1'b0;
      gap_d      = 1'b0;
    end
  end

  assign q_wr_o = accept && (has_code || in_item_i.end_of_text);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_sent_q <= 1'b0;
      gap_q      <= 1'b0;
    end else if (accept) begin
      any_sent_q <= any_sent_d;
      gap_q      <= gap_d;
    end
  end

  // A gap is only owed once a character went out
  a_gap_needs_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q |-> any_sent_q) else $error("gap pending with nothing sent");
  // Separators only precede a real code
  a_sep_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o && q_data_o.sep != SepNone |-> q_data_o.len != 3'd0)
    else $error("separator job without code");
  // A middle byte without a code never makes a job
  a_no_empty_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o && q_data_o.len == 3'd0 |-> q_data_o.last)
    else $error("empty job that is not an end marker");

endmodule
`default_nettype wire

/* hdl/mte_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mte_fifo
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module mte_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 wr_i,
  input  mte_pkg::mte_job_t   wr_data_i,
  output logic                full_o,
  input  wire                 rd_i,
  output mte_pkg::mte_job_t   rd_data_o,
  output logic                empty_o
);
  import mte_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [AW:0]   FullCnt = (AW + 1)'(DEPTH);

  mte_job_t      mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> wr_ptr_q == rd_ptr_q) else $error("queue pointers out of step");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count step");

endmodule
`default_nettype wire

/* hdl/mte_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mte_back
// Serializes jobs into output bytes through an output register, one per
// cycle unless the output register is held because pop is low.
// ----------------------------------------------------------------------------
module mte_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_wdata_i,
  input  mte_pkg::mte_job_t   q_data_i,
  input  wire                 q_empty_i,
  output logic                q_rd_o,
  output mte_pkg::mte_out_t   out_item_o,
  output logic                empty_o,
  input  wire                 pop_i
);
  import mte_pkg::*;

  logic     style_q;
  logic     busy_q, busy_d;
  mte_job_t job_q, job_d;
  logic     out_valid_q;
  mte_out_t out_q, out_d;
  mte_job_t cur;
  logic     have, advance, final_step, elem;

  // Current job: remainder in flight, else queue head
  assign cur        = busy_q ? job_q : q_data_i;
  assign have       = busy_q || !q_empty_i;
  assign advance    = have && (!out_valid_q || pop_i);
  assign q_rd_o     = advance && !busy_q;
  assign elem       = cur.pat[cur.len - 3'd1];

  // Next byte of the current job
  always_comb begin
    job_d             = cur;
    out_d.symbol      = CharNone;
    out_d.symbol_valid = 1'b1;
    if (cur.sep != SepNone) begin
      out_d.symbol = CharSpace;
      job_d.sep    = cur.sep - 2'd1;
    end else if (cur.len != 3'd0) begin
      if (style_q) begin
        out_d.symbol = elem ? CharOne : CharZero;
      end else begin
        out_d.symbol = elem ? CharDash : CharDot;
      end
      job_d.len = cur.len - 3'd1;
    end else begin
      out_d.symbol_valid = 1'b0;
    end
    final_step         = (job_d.sep == SepNone) && (job_d.len == 3'd0);
    out_d.run_last     = final_step;
    out_d.message_done = final_step && cur.last;
    busy_d             = !final_step;
  end

  // Style register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= 1'b0;
    end else if (cfg_we_i) begin
      style_q <= cfg_wdata_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        busy_q      <= busy_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      job_q <= job_d;
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;
  assign empty_o    = !out_valid_q;

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.sep != SepNone || job_q.len != 3'd0))
    else $error("busy with no work left");
  a_sep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> job_q.sep != 2'd3) else $error("bad separator count");
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.symbol_valid |-> out_q.run_last && out_q.message_done)
    else $error("bare result that does not end a message");

endmodule
`default_nettype wire

/* hdl/morse_text_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// morse_text_encoder
// International Morse code text encoder, one text byte in, output bytes out.
// ----------------------------------------------------------------------------
// Input: write a byte with push while full is low. Output: while empty is
// low, out_item_o holds the oldest result; pop takes it.
// cfg_we_i writes cfg_wdata_i to the style bit (0: '.'/'-', 1: '0'/'1').
// One text byte yields 0 to 9 result bytes: up to two spaces and up to seven
// elements. The back end emits one result byte per cycle while pop keeps
// the output register free; a byte with no output is taken at the input
// and makes no job. The first result of a byte passes through the job queue
// and then the output register before it is visible.
// A job queue of QUEUE_DEPTH entries sits between the lookup and the
// serializer, so input keeps flowing while long codes drain.
// When pop stays low the output register holds; the queue fills and full
// rises, stalling the input. Reset empties the queue and the output register,
// and clears the message state and the style bit.
// ----------------------------------------------------------------------------
module morse_text_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push,
  input  mte_pkg::mte_in_t   in_item_i,
  output logic               full,
  input  wire                pop,
  output mte_pkg::mte_out_t  out_item_o,
  output logic               empty,
  input  wire                cfg_we_i,
  input  wire                cfg_wdata_i
);
  import mte_pkg::*;

  logic     q_wr, q_rd, q_full, q_empty;
  mte_job_t q_wdata, q_rdata;

  assign full = q_full;

  mte_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata)
  );

  mte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  mte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_rd_o      (q_rd),
    .out_item_o  (out_item_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
`default_nettype wire

/* dv/morse_text_encoder_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// morse_text_encoder_tb
// Self-checking bench for the Morse text encoder.
// ----------------------------------------------------------------------------
// A driver pushes text bytes from a plan queue and a monitor predicts every
// output byte at the moment a request is taken. Results are compared field by
// field in order. A short directed message set covers the 1- and 7-element
// codes, case folding, word gap collapsing, unsupported bytes, leading and
// trailing gap trimming and the bare end marker in both symbol styles.
// Random messages with noise then follow, with random stalls on both sides.
// The style bit is only changed while the encoder is fully drained.
// ----------------------------------------------------------------------------
module morse_text_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mte_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int IdleWait    = 8;     // cycles without a request before a style write
  localparam int DrainCycles = 20;
  localparam int RandomItems = 360;
  localparam int MaxReports  = 10;

  // Control bytes treated as whitespace
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChCr  = 8'h0D;

  typedef enum logic {StepChar, StepStyle} step_kind_e;

  typedef struct {
    step_kind_e kind;
    mte_in_t    req;
    logic       style;
  } step_t;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  mte_in_t  in_item_i;
  logic     full;
  logic     pop;
  mte_out_t out_item_o;
  logic     empty;
  logic     cfg_we_i;
  logic     cfg_wdata_i;

  step_t    plan[$];
  mte_out_t expected_symbols[$];

  // Encoder state as seen by the bench
  logic     style_bit;
  logic     char_sent;
  logic     word_gap_owed;

  // Handshake bookkeeping shared between the edges
  logic     push_fired;
  logic     pop_fired;
  int       quiet_cycles;
  int       tx_gap;
  int       rx_gap;
  bit       tx_steady;
  bit       rx_steady;
  int       mismatches;
  int       plan_items;

  morse_text_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .empty       (empty),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock, reset and known input levels
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_item_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    push_fired    = 1'b0;
    pop_fired     = 1'b0;
    quiet_cycles  = 0;
    tx_gap        = 0;
    rx_gap        = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    mismatches    = 0;
    style_bit     = 1'b0;
    char_sent     = 1'b0;
    word_gap_owed = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Element string of an upper-case byte, '1' for a dash; empty if unsupported
  function automatic string morse_elements(input logic [7:0] ch);
    case (ch)
      "!":   return "101011";
      "$":   return "0001001";
      8'h22: return "010010";
      8'h27: return "011110";
      "(":   return "10110";
      ")":   return "101101";
      ",":   return "110011";
      "-":   return "100001";
      ".":   return "010101";
      "/":   return "10010";
      "0":   return "11111";
      "1":   return "01111";
      "2":   return "00111";
      "3":   return "00011";
      "4":   return "00001";
      "5":   return "00000";
      "6":   return "10000";
      "7":   return "11000";
      "8":   return "11100";
      "9":   return "11110";
      ":":   return "111000";
      ";":   return "101010";
      "=":   return "10001";
      "?":   return "001100";
      "@":   return "011010";
      "A":   return "01";
      "B":   return "1000";
      "C":   return "1010";
      "D":   return "100";
      "E":   return "0";
      "F":   return "0010";
      "G":   return "110";
      "H":   return "0000";
      "I":   return "00";
      "J":   return "0111";
      "K":   return "101";
      "L":   return "0100";
      "M":   return "11";
      "N":   return "10";
      "O":   return "111";
      "P":   return "0110";
      "Q":   return "1101";
      "R":   return "010";
      "S":   return "000";
      "T":   return "1";
      "U":   return "001";
      "V":   return "0001";
      "W":   return "011";
      "X":   return "1001";
      "Y":   return "1011";
      "Z":   return "1100";
      "_":   return "001101";
      default: return "";
    endcase
  endfunction

  // Predict the output bytes of one accepted text byte
  task automatic encode_request(input mte_in_t req);
    logic [7:0] ch;
    string      elems;
    mte_out_t   burst [9];
    int         n;
    int         i;
    ch = req.char_code;
    n  = 0;
    if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
    elems = morse_elements(ch);
    if (elems.len() == 0) begin
      // separator or unsupported byte: owe a word gap once text has started
      if (char_sent) word_gap_owed = 1'b1;
    end else begin
      if (char_sent) begin
        burst[n] = '{symbol: CharSpace, symbol_valid: 1'b1, default: 1'b0};
        n++;
        if (word_gap_owed) begin
          burst[n] = '{symbol: CharSpace, symbol_valid: 1'b1, default: 1'b0};
          n++;
        end
      end
      for (i = 0; i < elems.len(); i++) begin
        burst[n] = '{symbol: CharNone, default: 1'b0};
        burst[n].symbol_valid = 1'b1;
        if (style_bit) burst[n].symbol = (elems[i] == "1") ? CharOne : CharZero;
        else           burst[n].symbol = (elems[i] == "1") ? CharDash : CharDot;
        n++;
      end
      char_sent     = 1'b1;
      word_gap_owed = 1'b0;
    end
    if (req.end_of_text) begin
      // empty tail still closes the message with a bare marker
      if (n == 0) begin
        burst[n] = '{symbol: CharNone, default: 1'b0};
        n++;
      end
      burst[n - 1].message_done = 1'b1;
      char_sent     = 1'b0;
      word_gap_owed = 1'b0;
    end
    if (n > 0) burst[n - 1].run_last = 1'b1;
    for (i = 0; i < n; i++) expected_symbols.insert(expected_symbols.size(), burst[i]);
  endtask

  task automatic note_mismatch(input string what, input mte_out_t want, input mte_out_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t %s: want sym=%h v=%b rl=%b md=%b, got sym=%h v=%b rl=%b md=%b",
               $realtime, what, want.symbol, want.symbol_valid, want.run_last,
               want.message_done, got.symbol, got.symbol_valid, got.run_last,
               got.message_done);
  endtask

  task automatic check_symbol(input mte_out_t got);
    mte_out_t want;
    if (expected_symbols.size() == 0) begin
      note_mismatch("unexpected result", '0, got);
    end else begin
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
          got.run_last !== want.run_last || got.message_done !== want.message_done)
        note_mismatch("result mismatch", want, got);
    end
  endtask

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Monitor: sample both handshakes and the style write at the rising edge
  always @(posedge clk_i) begin
    push_fired = rst_ni && push && !full;
    pop_fired  = rst_ni && pop && !empty;
    if (rst_ni) begin
      if (cfg_we_i) style_bit = cfg_wdata_i;
      if (push_fired) encode_request(in_item_i);
      if (pop_fired) check_symbol(out_item_o);
      if (push_fired) quiet_cycles = 0;
      else if (quiet_cycles < 1000) quiet_cycles++;
    end
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push_fired) begin
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        tx_gap = pick_gap(tx_steady);
      end
      if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
      end else if (push && !push_fired) begin
        // request still waiting for room
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (plan.size() == 0) begin
        push <= 1'b0;
      end else if (plan[0].kind == StepChar) begin
        in_item_i <= plan[0].req;
        push      <= 1'b1;
        void'(plan.pop_front());
      end else if (expected_symbols.size() == 0 && quiet_cycles >= IdleWait) begin
        // encoder drained: safe to change the style
        push        <= 1'b0;
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= plan[0].style;
        void'(plan.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result acceptor
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_fired) begin
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        rx_gap = pick_gap(rx_steady);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_char(input logic [7:0] ch, input logic eot);
    step_t s;
    s.kind                 = StepChar;
    s.req.char_code        = ch;
    s.req.end_of_text      = eot;
    s.style                = 1'b0;
    plan.insert(plan.size(), s);
    plan_items++;
  endtask

  task automatic add_style(input logic value);
    step_t s;
    s.kind  = StepStyle;
    s.req   = '0;
    s.style = value;
    plan.insert(plan.size(), s);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0: return ChTab;
      1: return ChLf;
      2: return ChVt;
      3: return ChFf;
      4: return ChCr;
      default: return CharSpace;
    endcase
  endfunction

  // Random message: words of supported characters, whitespace runs and noise
  task automatic add_message();
    string      charset;
    logic [7:0] text[$];
    int         words;
    int         w;
    int         k;
    int         i;
    charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!$\"'(),-./:;=?@_";
    words   = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) text.insert(text.size(), pick_space());
    for (w = 0; w < words; w++) begin
      for (k = $urandom_range(1, 6); k > 0; k--) begin
        if ($urandom_range(0, 99) < 85)
          text.insert(text.size(), charset[$urandom_range(0, charset.len() - 1)]);
        else
          text.insert(text.size(), 8'($urandom_range(0, 255)));
      end
      if (w < words - 1)
        for (k = $urandom_range(1, 3); k > 0; k--) text.insert(text.size(), pick_space());
    end
    if ($urandom_range(0, 3) == 0) text.insert(text.size(), pick_space());
    for (i = 0; i < text.size(); i++) add_char(text[i], i == text.size() - 1);
  endtask

  // Stimulus plan and end of run
  initial begin
    int   phase_items;
    logic phase_style;
    plan_items = 0;

    // Style 0: trimming, gap collapsing, case folding, longest and shortest codes
    add_style(1'b0);
    add_char(CharSpace, 1'b0);
    add_char("E", 1'b0);
    add_char(CharSpace, 1'b0);
    add_char(ChTab, 1'b0);
    add_char("$", 1'b0);
    add_char(8'hFF, 1'b0);
    add_char("a", 1'b0);
    add_char("z", 1'b0);
    add_char("_", 1'b0);
    add_char(ChLf, 1'b1);
    add_char("Q", 1'b1);
    add_char(8'h00, 1'b1);
    add_char("!", 1'b0);
    add_char(ChCr, 1'b0);
    add_char(ChVt, 1'b0);
    add_char(ChFf, 1'b0);
    add_char("0", 1'b0);
    add_char("9", 1'b1);

    // Style 1, ending in a pending gap that is dropped
    add_style(1'b1);
    add_char("S", 1'b0);
    add_char("O", 1'b0);
    add_char(8'h80, 1'b0);
    add_char("@", 1'b0);
    add_char("7", 1'b0);
    add_char(CharSpace, 1'b1);

    // Random phases, style flipped between them on a drained encoder
    phase_style = 1'b0;
    add_style(phase_style);
    phase_items = plan_items;
    while (plan_items < 25 + RandomItems) begin
      add_message();
      if (plan_items - phase_items >= 80) begin
        phase_style = !phase_style;
        add_style(phase_style);
        phase_items = plan_items;
      end
    end

    @(posedge rst_ni);
    while (plan.size() > 0 || push || cfg_we_i || expected_symbols.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_symbols.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
